@@ design/lpc_pkg.sv @@
// Package for the line printer canonicalizer: shared types, character codes and limits.
// Used by every module of the block. It depends on nothing else.
package lpc_pkg;

   // Column widths and limits
   localparam int unsigned COL_W                = 10;
   localparam int unsigned PCOL_W               = 8;
   localparam int unsigned CHAR_W               = 8;
   localparam logic [COL_W-1:0] LOGICAL_COLUMN_LIMIT = COL_W'(1000);
   localparam logic [7:0]  PRINT_WIDTH_RESET    = 8'd132;
   localparam logic [COL_W:0] TAB_STEP          = (COL_W+1)'(8);
   localparam logic [COL_W:0] TAB_STOP_MASK     = ~((COL_W+1)'(7));

   // Register file
   localparam int unsigned CSR_INDEX_W          = 1;
   localparam int unsigned CSR_DATA_W           = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPS_MODE   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRINT_WIDTH = 1'b1;

   // Queue between the front and back ends
   localparam int unsigned QUEUE_DEPTH          = 2;
   localparam int unsigned QUEUE_PTR_W          = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W          = $clog2(QUEUE_DEPTH + 1);

   // Character codes
   localparam logic [CHAR_W-1:0] CHAR_BS        = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_NL        = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_FF        = 8'h0C;
   localparam logic [CHAR_W-1:0] CHAR_CR        = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_HYPHEN    = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A   = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z   = 8'h7A;
   localparam logic [CHAR_W-1:0] CASE_OFFSET    = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_LBRACE    = 8'h7B;
   localparam logic [CHAR_W-1:0] CHAR_RBRACE    = 8'h7D;
   localparam logic [CHAR_W-1:0] CHAR_BACKQUOTE = 8'h60;
   localparam logic [CHAR_W-1:0] CHAR_BAR       = 8'h7C;
   localparam logic [CHAR_W-1:0] CHAR_TILDE     = 8'h7E;
   localparam logic [CHAR_W-1:0] CHAR_LPAREN    = 8'h28;
   localparam logic [CHAR_W-1:0] CHAR_RPAREN    = 8'h29;
   localparam logic [CHAR_W-1:0] CHAR_QUOTE     = 8'h27;
   localparam logic [CHAR_W-1:0] CHAR_BANG      = 8'h21;
   localparam logic [CHAR_W-1:0] CHAR_CARET     = 8'h5E;

   // Operation that the back end carries out for one request
   typedef enum logic [2:0] {
      OP_PRINT,
      OP_OVER,
      OP_SPACE,
      OP_TAB,
      OP_CR,
      OP_BS,
      OP_NL,
      OP_FF
   } op_type;

   // One classified request as it sits in the queue
   typedef struct packed {
      op_type            op;
      logic [CHAR_W-1:0] ch;
   } entry_type;

   // One result as held in the output register
   typedef struct packed {
      logic              return_first;
      logic [7:0]        space_count;
      logic [CHAR_W-1:0] out_char;
      logic              last;
   } result_type;

endpackage

@@ design/lpc_front.sv @@
// Front end of the line printer canonicalizer: classifies each request byte.
// Depends on lpc_pkg; feeds lpc_queue.
module lpc_front (
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,
   input  logic                    caps_mode,
   input  logic                    queue_full,
   output logic                    push,
   output lpc_pkg::entry_type      entry
);
   import lpc_pkg::*;

   // A request goes straight into the queue whenever there is room.
   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   // Map the byte to an operation; caps mode folds case and picks overstrike substitutes.
   always_comb begin
      entry.op = OP_PRINT;
      entry.ch = req_tdata;
      priority if (caps_mode && req_tdata >= CHAR_LOWER_A && req_tdata <= CHAR_LOWER_Z) begin
         entry.ch = req_tdata - CASE_OFFSET;
      end else if (caps_mode && req_tdata == CHAR_LBRACE) begin
         entry.op = OP_OVER;
         entry.ch = CHAR_LPAREN;
      end else if (caps_mode && req_tdata == CHAR_RBRACE) begin
         entry.op = OP_OVER;
         entry.ch = CHAR_RPAREN;
      end else if (caps_mode && req_tdata == CHAR_BACKQUOTE) begin
         entry.op = OP_OVER;
         entry.ch = CHAR_QUOTE;
      end else if (caps_mode && req_tdata == CHAR_BAR) begin
         entry.op = OP_OVER;
         entry.ch = CHAR_BANG;
      end else if (caps_mode && req_tdata == CHAR_TILDE) begin
         entry.op = OP_OVER;
         entry.ch = CHAR_CARET;
      end else if (req_tdata == CHAR_SPACE) begin
         entry.op = OP_SPACE;
      end else if (req_tdata == CHAR_TAB) begin
         entry.op = OP_TAB;
      end else if (req_tdata == CHAR_FF) begin
         entry.op = OP_FF;
      end else if (req_tdata == CHAR_NL) begin
         entry.op = OP_NL;
      end else if (req_tdata == CHAR_CR) begin
         entry.op = OP_CR;
      end else if (req_tdata == CHAR_BS) begin
         entry.op = OP_BS;
      end else begin
         entry.op = OP_PRINT;
      end
   end

endmodule

@@ design/lpc_queue.sv @@
// Short queue of classified requests between the front and back ends.
// Depends on lpc_pkg for the entry type and depth.
module lpc_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  lpc_pkg::entry_type      push_entry,
   output logic                    full,
   input  logic                    pop,
   output logic                    head_valid,
   output lpc_pkg::entry_type      head_entry
);
   import lpc_pkg::*;

   entry_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ design/lpc_back.sv @@
// Back end of the line printer canonicalizer: keeps the column state, runs one output step per
// cycle unless a result must wait for the output register, and holds the result register. Depends on lpc_pkg.
module lpc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              print_width,
   input  logic                    head_valid,
   input  lpc_pkg::entry_type      head_entry,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output lpc_pkg::result_type     rsp_result
);
   import lpc_pkg::*;

   logic [COL_W-1:0]   lc_ff, lc_in;
   logic [PCOL_W-1:0]  pc_ff, pc_in;
   logic               lsp_ff, lsp_in;
   logic               phase_ff, phase_in;
   logic               valid_ff, valid_in;
   result_type         result_ff;

   logic [CHAR_W-1:0]  cur_ch;
   logic [COL_W:0]     lc_inc_wide;
   logic [COL_W-1:0]   lc_inc_sat;
   logic [COL_W:0]     lc_tab_wide;
   logic [COL_W-1:0]   lc_tab_sat;
   logic [COL_W-1:0]   lc_dec;
   logic [COL_W-1:0]   lc_over;
   logic               over_last;
   logic               print_ok;
   logic               ret;
   logic               ff_dropped;
   logic               emit;
   logic               done;
   logic               slot_free;
   logic               advance;
   result_type         step_result;

   // The second step of an overstrike prints a hyphen when it falls inside the print width.
   assign cur_ch = phase_ff ? CHAR_HYPHEN : head_entry.ch;

   // Column arithmetic, saturated at the logical limit
   assign lc_inc_wide = {1'b0, lc_ff} + (COL_W+1)'(1);
   assign lc_inc_sat  = (lc_inc_wide > {1'b0, LOGICAL_COLUMN_LIMIT}) ? LOGICAL_COLUMN_LIMIT
                        : lc_inc_wide[COL_W-1:0];
   assign lc_tab_wide = ({1'b0, lc_ff} + TAB_STEP) & TAB_STOP_MASK;
   assign lc_tab_sat  = (lc_tab_wide > {1'b0, LOGICAL_COLUMN_LIMIT}) ? LOGICAL_COLUMN_LIMIT
                        : lc_tab_wide[COL_W-1:0];
   assign lc_dec      = (lc_ff == '0) ? '0 : lc_ff - COL_W'(1);
   // After the substitute the column steps back for the hyphen.
   assign lc_over     = lc_inc_sat - COL_W'(1);
   assign over_last   = !(lc_over < {{(COL_W-8){1'b0}}, print_width});

   // Printable step: the head returns first when it is right of the column.
   assign print_ok   = lc_ff < {{(COL_W-8){1'b0}}, print_width};
   assign ret        = {{(COL_W-PCOL_W){1'b0}}, pc_ff} > lc_ff;
   assign ff_dropped = !lsp_ff && (pc_ff == '0);

   // One step of the current request
   always_comb begin
      lc_in                    = lc_ff;
      pc_in                    = pc_ff;
      lsp_in                   = lsp_ff;
      phase_in                 = phase_ff;
      emit                     = 1'b0;
      done                     = 1'b1;
      step_result.return_first = ret;
      step_result.space_count  = lc_ff[PCOL_W-1:0] - (ret ? '0 : pc_ff);
      step_result.out_char     = cur_ch;
      step_result.last         = 1'b1;
      unique case (head_entry.op)
         OP_PRINT: begin
            emit  = print_ok;
            lc_in = lc_inc_sat;
            if (print_ok) begin
               pc_in = lc_ff[PCOL_W-1:0] + PCOL_W'(1);
            end
         end
         OP_OVER: begin
            emit = print_ok;
            if (print_ok) begin
               pc_in = lc_ff[PCOL_W-1:0] + PCOL_W'(1);
            end
            if (!phase_ff) begin
               lc_in            = lc_over;
               step_result.last = over_last;
               phase_in         = 1'b1;
               done             = 1'b0;
            end else begin
               lc_in    = lc_inc_sat;
               phase_in = 1'b0;
            end
         end
         OP_SPACE: begin
            lc_in = lc_inc_sat;
         end
         OP_TAB: begin
            lc_in = lc_tab_sat;
         end
         OP_CR: begin
            lc_in = '0;
         end
         OP_BS: begin
            lc_in = lc_dec;
         end
         OP_NL: begin
            emit                     = 1'b1;
            step_result.return_first = 1'b0;
            step_result.space_count  = '0;
            lc_in                    = '0;
            pc_in                    = '0;
            lsp_in                   = 1'b1;
         end
         OP_FF: begin
            if (!ff_dropped) begin
               emit                     = 1'b1;
               step_result.return_first = 1'b0;
               step_result.space_count  = '0;
               lc_in                    = '0;
               pc_in                    = '0;
               lsp_in                   = 1'b0;
            end
         end
         default: begin
            lc_in = lc_ff;
         end
      endcase
   end

   // A step goes ahead when it sends nothing or the output register can take it.
   assign slot_free = !valid_ff || rsp_ready;
   assign advance   = head_valid && (!emit || slot_free);
   assign pop       = advance && done;

   always_comb begin
      valid_in = valid_ff;
      if (advance && emit) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         lc_ff    <= '0;
         pc_ff    <= '0;
         lsp_ff   <= 1'b0;
         phase_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (advance) begin
            lc_ff    <= lc_in;
            pc_ff    <= pc_in;
            lsp_ff   <= lsp_in;
            phase_ff <= phase_in;
         end
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      if (advance && emit) begin
         result_ff <= step_result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

@@ design/line_printer_canonicalizer.sv @@
// Line printer canonicalizer: takes one byte per request and sends out what the
// printer must print. A front end classifies each byte and places it in a two-entry
// queue; a back end keeps the logical column, the physical column and the top-of-page
// flag and works through the queue one output step per cycle into a result register, unless
// that register is still held by an untaken result. The back end handles a request in one
// step, or in a substitute step and then a hyphen step when caps mode overstrikes it; that
// back-end step is what sets the rate. When nothing stalls, the first result of a request
// passes through the queue slot and then the result register before it is offered. Each result
// is a character with an optional carriage return and a count of spaces to send before
// it; tlast marks the final result of a request, and a request may give none.
// Registers: index 0 caps_mode (bit 0), index 1 print_width (reset 132). Write them
// only while the block is idle. Depends on lpc_pkg, lpc_front, lpc_queue and lpc_back.
module line_printer_canonicalizer (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] character
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [23:0]  rsp_tdata,   // [0] return_first, [8:1] space_count, [16:9] out_char
   output logic         rsp_tlast,
   input  logic         csr_wen,
   input  logic [lpc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lpc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lpc_pkg::*;

   logic         caps_mode_ff;
   logic [7:0]   print_width_ff;
   logic         queue_full;
   logic         push;
   entry_type    push_entry;
   logic         pop;
   logic         head_valid;
   entry_type    head_entry;
   result_type   rsp_result;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         caps_mode_ff   <= 1'b0;
         print_width_ff <= PRINT_WIDTH_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_CAPS_MODE:   caps_mode_ff   <= csr_wdata[0];
            CSR_PRINT_WIDTH: print_width_ff <= csr_wdata[7:0];
            default:         caps_mode_ff   <= caps_mode_ff;
         endcase
      end
   end

   lpc_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .caps_mode  (caps_mode_ff),
      .queue_full (queue_full),
      .push       (push),
      .entry      (push_entry)
   );

   lpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   lpc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .print_width (print_width_ff),
      .head_valid  (head_valid),
      .head_entry  (head_entry),
      .pop         (pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_result  (rsp_result)
   );

   // Pack the result fields, lowest first, padded to whole bytes.
   assign rsp_tdata = {7'b0, rsp_result.out_char, rsp_result.space_count,
                       rsp_result.return_first};
   assign rsp_tlast = rsp_result.last;

endmodule

@@ design/lpc_checker.sv @@
// Port-level checks for the line printer canonicalizer, bound to the top level.
// Depends on lpc_pkg for character codes.
module lpc_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [23:0]  rsp_tdata,
   input  logic         rsp_tlast
);
   import lpc_pkg::*;

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Newline and form feed go out with no return and no spaces.
   a_line_end_plain: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[16:9] == CHAR_NL || rsp_tdata[16:9] == CHAR_FF)
      |-> rsp_tdata[8:0] == 9'd0)
      else $error("line end carries return or spaces");

   // The space count never reaches the full byte range, and the padding bits stay zero.
   a_space_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[8:1] != 8'hFF && rsp_tdata[23:17] == 7'd0)
      else $error("space count or padding out of range");

   // Only an overstrike substitute can be followed by a second result.
   a_non_last_substitute: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |->
      rsp_tdata[16:9] == CHAR_LPAREN || rsp_tdata[16:9] == CHAR_RPAREN ||
      rsp_tdata[16:9] == CHAR_QUOTE || rsp_tdata[16:9] == CHAR_BANG ||
      rsp_tdata[16:9] == CHAR_CARET)
      else $error("non-final result is not an overstrike substitute");

endmodule

bind line_printer_canonicalizer lpc_checker u_lpc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
